### hdl/rpfa_pkg.sv
`timescale 1ns / 1ps
package rpfa_pkg;

    // Managed page space and the derived widths
    localparam int NUM_PAGES = 32768;
    localparam int ADDR_W    = $clog2(NUM_PAGES);
    localparam int DEPTH_W   = $clog2(NUM_PAGES + 1);

    // Fixed field widths
    localparam int MODE_W   = 2;
    localparam int PAGE_W   = 15;
    localparam int END_W    = 16;
    localparam int CNT_W    = 8;
    localparam int STATUS_W = 3;
    localparam int FREE_W   = 16;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 48;
    localparam int CFG_W    = 16;

    // Common compare width for page numbers, bounds and depth
    localparam int CMP_W = (DEPTH_W > END_W) ? DEPTH_W : END_W;
    localparam logic [CMP_W-1:0] NUM_PAGES_C = CMP_W'(NUM_PAGES);
    localparam logic [CMP_W-1:0] LAST_PAGE_C = CMP_W'(NUM_PAGES - 1);

    localparam logic [END_W-1:0] END_RESET = END_W'(32768);
    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

    // Configuration register indexes
    localparam logic CFG_FIRST_PAGE = 1'b0;
    localparam logic CFG_END_PAGE   = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_INIT   = 2'd0,
        MODE_ALLOC  = 2'd1,
        MODE_FREE   = 2'd2,
        MODE_ADDREF = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_RANGE    = 3'd2,
        ST_BADCOUNT = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_step;
        logic load_in;
        logic init_start;
        logic init_step;
        logic stack_rd;
        logic cnt_rd_page;
        logic cnt_rd_top;
        logic exec;
    } rpfa_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic  clear_last;
        logic  init_done;
        logic  depth_zero;
        logic  out_free;
        mode_t mode;
    } rpfa_stat_t;

    function automatic logic [ADDR_W-1:0] to_addr(input logic [CMP_W-1:0] v);
        return v[ADDR_W-1:0];
    endfunction

endpackage

### hdl/rpfa_ram.sv
`timescale 1ns / 1ps
module rpfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/rpfa_ctrl.sv
`timescale 1ns / 1ps
module rpfa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rpfa_pkg::rpfa_stat_t stat,
    output rpfa_pkg::rpfa_cmd_t  cmd
);
    import rpfa_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_DECODE = 6'b000100,
        S_STACK  = 6'b001000,
        S_INIT   = 6'b010000,
        S_EXEC   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.mode)
                    MODE_INIT:
                    begin
                        cmd.init_start = 1'b1;
                        state_next     = S_INIT;
                    end
                    MODE_ALLOC:
                    begin
                        if (stat.depth_zero)
                        begin
                            state_next = S_EXEC;
                        end
                        else
                        begin
                            cmd.stack_rd = 1'b1;
                            state_next   = S_STACK;
                        end
                    end
                    MODE_FREE, MODE_ADDREF:
                    begin
                        cmd.cnt_rd_page = 1'b1;
                        state_next      = S_EXEC;
                    end
                    default:
                    begin
                        state_next = S_EXEC;
                    end
                endcase
            end
            S_STACK:
            begin
                cmd.cnt_rd_top = 1'b1;
                state_next     = S_EXEC;
            end
            S_INIT:
            begin
                if (stat.init_done)
                begin
                    state_next = S_EXEC;
                end
                else
                begin
                    cmd.init_step = 1'b1;
                end
            end
            S_EXEC:
            begin
                if (stat.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

### hdl/rpfa_dp.sv
`timescale 1ns / 1ps
module rpfa_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rpfa_pkg::rpfa_cmd_t          cmd,
    output rpfa_pkg::rpfa_stat_t         stat,
    input  logic [rpfa_pkg::IN_W-1:0]    in_data,
    input  logic [rpfa_pkg::MODE_W-1:0]  in_user,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [rpfa_pkg::OUT_W-1:0]   out_data,
    input  logic                         cfg_valid,
    input  logic                         cfg_index,
    input  logic [rpfa_pkg::CFG_W-1:0]   cfg_data
);
    import rpfa_pkg::*;

    logic [PAGE_W-1:0]  first_reg;
    logic [END_W-1:0]   end_reg;
    mode_t              mode_reg;
    logic [PAGE_W-1:0]  page_reg;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [CMP_W-1:0]   walk_reg, walk_next;
    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg;

    logic [CNT_W-1:0]   cnt_q;
    logic [PAGE_W-1:0]  top_q;

    logic [CMP_W-1:0]   pg_w, first_w, end_w, eff_end_w, depth_w, top_w;
    logic               pg_in_mem, depth_ok, out_free;

    // Result of the current request
    logic [PAGE_W-1:0]  r_page;
    logic               r_valid, r_released;
    status_t            r_status;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_cnt_we, r_pop, r_push;
    logic [CNT_W-1:0]   r_cnt_new;
    logic [ADDR_W-1:0]  r_cnt_addr;

    logic               cnt_we, cnt_re, stk_we, stk_re;
    logic [ADDR_W-1:0]  cnt_waddr, cnt_raddr, stk_waddr, stk_raddr;
    logic [CNT_W-1:0]   cnt_wdata;
    logic [PAGE_W-1:0]  stk_wdata;

    assign pg_w      = CMP_W'(page_reg);
    assign first_w   = CMP_W'(first_reg);
    assign end_w     = CMP_W'(end_reg);
    assign eff_end_w = (end_w < NUM_PAGES_C) ? end_w : NUM_PAGES_C;
    assign depth_w   = CMP_W'(depth_reg);
    assign top_w     = CMP_W'(top_q);
    assign pg_in_mem = pg_w < NUM_PAGES_C;
    assign depth_ok  = depth_w < NUM_PAGES_C;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        r_page     = page_reg;
        r_valid    = 1'b0;
        r_released = 1'b0;
        r_status   = ST_OK;
        r_cnt      = '0;
        r_cnt_we   = 1'b0;
        r_cnt_new  = '0;
        r_cnt_addr = to_addr(pg_w);
        r_pop      = 1'b0;
        r_push     = 1'b0;
        unique case (mode_reg)
            MODE_ALLOC:
            begin
                r_cnt_addr = to_addr(top_w);
                if (depth_reg == '0)
                begin
                    r_status = ST_EMPTY;
                end
                else if (top_w >= NUM_PAGES_C)
                begin
                    r_status = ST_RANGE;
                end
                else if (cnt_q != '0)
                begin
                    r_status = ST_BADCOUNT;
                    r_cnt    = cnt_q;
                end
                else
                begin
                    r_cnt_we  = 1'b1;
                    r_cnt_new = CNT_W'(1);
                    r_pop     = 1'b1;
                    r_page    = top_q;
                    r_valid   = 1'b1;
                    r_cnt     = CNT_W'(1);
                end
            end
            MODE_FREE:
            begin
                if (pg_w < first_w || pg_w >= eff_end_w)
                begin
                    r_status = ST_RANGE;
                    r_cnt    = pg_in_mem ? cnt_q : '0;
                end
                else if (cnt_q == '0)
                begin
                    r_status = ST_BADCOUNT;
                end
                else
                begin
                    r_cnt_we  = 1'b1;
                    r_cnt_new = cnt_q - CNT_W'(1);
                    r_cnt     = r_cnt_new;
                    if (r_cnt_new == '0)
                    begin
                        r_released = 1'b1;
                        r_push     = depth_ok;
                    end
                end
            end
            MODE_ADDREF:
            begin
                if (pg_w >= eff_end_w)
                begin
                    r_status = ST_RANGE;
                    r_cnt    = pg_in_mem ? cnt_q : '0;
                end
                else if (cnt_q == '0)
                begin
                    r_status = ST_BADCOUNT;
                end
                else if (cnt_q == CNT_MAX)
                begin
                    r_status = ST_OVERFLOW;
                    r_cnt    = CNT_MAX;
                end
                else
                begin
                    r_cnt_we  = 1'b1;
                    r_cnt_new = cnt_q + CNT_W'(1);
                    r_cnt     = r_cnt_new;
                end
            end
            default:
            begin
                // init echoes the page and reports the fill level
            end
        endcase
    end

    // Memory port steering
    always_comb
    begin
        cnt_we    = cmd.clear_step || cmd.init_step || (cmd.exec && r_cnt_we);
        cnt_waddr = (cmd.clear_step || cmd.init_step) ? to_addr(walk_reg) : r_cnt_addr;
        cnt_wdata = (cmd.clear_step || cmd.init_step) ? '0 : r_cnt_new;
        cnt_re    = cmd.cnt_rd_page || cmd.cnt_rd_top;
        cnt_raddr = cmd.cnt_rd_top ? to_addr(top_w) : to_addr(pg_w);
        stk_we    = (cmd.init_step && depth_ok) || (cmd.exec && r_push);
        stk_waddr = to_addr(depth_w);
        stk_wdata = cmd.init_step ? walk_reg[PAGE_W-1:0] : page_reg;
        stk_re    = cmd.stack_rd;
        stk_raddr = to_addr(depth_w - CMP_W'(1));
    end

    always_comb
    begin
        depth_next = depth_reg;
        walk_next  = walk_reg;
        if (cmd.clear_step)
        begin
            walk_next = walk_reg + CMP_W'(1);
        end
        if (cmd.init_start)
        begin
            depth_next = '0;
            walk_next  = first_w;
        end
        if (cmd.init_step)
        begin
            walk_next = walk_reg + CMP_W'(1);
            if (depth_ok)
            begin
                depth_next = depth_reg + DEPTH_W'(1);
            end
        end
        if (cmd.exec && r_pop)
        begin
            depth_next = depth_reg - DEPTH_W'(1);
        end
        if (cmd.exec && r_push)
        begin
            depth_next = depth_reg + DEPTH_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg     <= '0;
            end_reg       <= END_RESET;
            depth_reg     <= '0;
            walk_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_FIRST_PAGE: first_reg <= cfg_data[PAGE_W-1:0];
                    CFG_END_PAGE:   end_reg   <= cfg_data[END_W-1:0];
                    default:        first_reg <= first_reg;
                endcase
            end
            depth_reg <= depth_next;
            walk_reg  <= walk_next;
            if (cmd.exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg <= mode_t'(in_user);
            page_reg <= in_data[PAGE_W-1:0];
        end
        if (cmd.exec)
        begin
            out_data_reg <= {4'b0000, FREE_W'(depth_next), r_cnt, r_released,
                             r_status, r_valid, r_page};
        end
    end

    rpfa_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_PAGES)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_q)
    );

    rpfa_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (NUM_PAGES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (top_q)
    );

    assign stat.clear_last = walk_reg == LAST_PAGE_C;
    assign stat.init_done  = walk_reg >= eff_end_w;
    assign stat.depth_zero = depth_reg == '0;
    assign stat.out_free   = out_free;
    assign stat.mode       = mode_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### hdl/refcounted_page_frame_allocator.sv
`timescale 1ns / 1ps
// A request is accepted, decoded and then executed into the result register, which may
// stall. Free and add-reference read the count memory while decoding; allocate reads the
// free stack, then the top page's count, and skips both on an empty stack. Init walks
// from first to end, one page a cycle. One request is handled at a time.
// Reset (rst_n, asynchronous, active low) clears control state, then a clearing pass
// zeroes every reference count; s_tready stays low until it ends.
module refcounted_page_frame_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    // Request stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rpfa_pkg::IN_W-1:0]     s_tdata,   // [14:0] page_number, [15] zero
    input  logic [rpfa_pkg::MODE_W-1:0]   s_tuser,   // [1:0] mode
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rpfa_pkg::OUT_W-1:0]    m_tdata,   // [14:0] page_out, [15] page_valid,
                                                     // [18:16] status, [19] page_released,
                                                     // [27:20] ref_count, [43:28] stack_fill,
                                                     // [47:44] zero
    // Configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index, // 0 first_page, 1 end_page
    input  logic [rpfa_pkg::CFG_W-1:0]    cfg_data
);
    import rpfa_pkg::*;

    rpfa_cmd_t  cmd;
    rpfa_stat_t stat;

    // Configuration registers are always writable; writes land in the datapath.
    assign cfg_ready = 1'b1;

    // Sequencer: clearing pass, request decode, init walk, execute.
    rpfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Count memory, free stack memory, bounds checks and the result register.
    // The result register lets a new request be accepted while a result waits.
    rpfa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_tdata),
        .in_user   (s_tuser),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

### hdl/rpfa_checker.sv
`timescale 1ns / 1ps
module rpfa_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [rpfa_pkg::IN_W-1:0]   s_tdata,
    input logic [rpfa_pkg::MODE_W-1:0] s_tuser,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [rpfa_pkg::OUT_W-1:0]  m_tdata,
    input logic                        cfg_valid,
    input logic                        cfg_ready,
    input logic                        cfg_index,
    input logic [rpfa_pkg::CFG_W-1:0]  cfg_data
);
    import rpfa_pkg::*;

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // One request at a time: ready drops right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while one is in flight");

    // A handed-out page is good and carries a count of one
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[15] |->
            m_tdata[18:16] == ST_OK && m_tdata[27:20] == 8'd1 && !m_tdata[19])
        else $error("bad allocate result");

    // A released page is good and has a count of zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[19] |-> m_tdata[18:16] == ST_OK && m_tdata[27:20] == 8'd0)
        else $error("bad release result");

endmodule

bind refcounted_page_frame_allocator rpfa_checker u_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import rpfa_pkg::*;

    // Run bounds: the clearing pass and a full-range init each walk the whole page space;
    // the limit stops a hung run and leaves a wide margin on top of a normal one.
    localparam int unsigned RUN_LIMIT    = 1_000_000;
    localparam int unsigned RANDOM_ITEMS = 950;
    localparam int unsigned DRAIN_CYCLES = 16;

    // One result, laid out as on m_tdata (first declared member in the top bits)
    typedef struct packed {
        logic [3:0]  pad;
        logic [15:0] stack_fill;
        logic [7:0]  ref_count;
        logic        page_released;
        status_t     status;
        logic        page_valid;
        logic [14:0] page_out;
    } alloc_result_t;

    // One line of the directed table: either a bounds write or a request,
    // with the result typed in where it is obvious
    typedef struct {
        bit            is_cfg;
        logic [15:0]   first_val;
        logic [15:0]   end_val;
        mode_t         mode;
        logic [14:0]   page;
        bit            typed;
        alloc_result_t result;
    } stim_row_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata   = '0;
    logic [MODE_W-1:0]   s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [OUT_W-1:0]    m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_index = CFG_FIRST_PAGE;
    logic [CFG_W-1:0]    cfg_data  = '0;

    // Shadow copy of the allocator: counts, free stack and bounds
    logic [7:0]          page_refs [NUM_PAGES];
    logic [14:0]         free_list [NUM_PAGES];
    int unsigned         free_depth;
    int unsigned         first_cfg;
    int unsigned         end_cfg;

    alloc_result_t       pending_results [$];
    stim_row_t           directed_rows [$];
    int unsigned         mismatches;
    int unsigned         requests_sent;
    int unsigned         cycle_count;
    int unsigned         burst_left;
    int unsigned         stall_left;
    int unsigned         stall_style;

    refcounted_page_frame_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Allocator prediction
    // ------------------------------------------------------------------

    // Upper bound actually in force: end_page clipped to the page space
    function automatic int unsigned managed_end();
        return (end_cfg < NUM_PAGES) ? end_cfg : NUM_PAGES;
    endfunction

    // Push a page on the free stack; a full stack drops the push
    function automatic void push_free(input int unsigned pg);
        if (free_depth < NUM_PAGES)
        begin
            free_list[free_depth] = pg[14:0];
            free_depth++;
        end
    endfunction

    // Apply one request to the shadow state and return the result it produces
    function automatic alloc_result_t predict_frame_op(input mode_t m, input logic [14:0] pg);
        alloc_result_t r;
        int unsigned   lim;
        int unsigned   p;
        logic [14:0]   top;
        r          = '0;
        r.page_out = pg;
        r.status   = ST_OK;
        lim        = managed_end();
        case (m)
            MODE_INIT:
            begin
                // Rebuild the stack from the managed range, lowest page first
                free_depth = 0;
                for (p = first_cfg; p < lim; p++)
                begin
                    page_refs[p] = '0;
                    push_free(p);
                end
            end
            MODE_ALLOC:
            begin
                if (free_depth == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    top = free_list[free_depth - 1];
                    if (page_refs[top] != 0)
                    begin
                        // Top page still referenced: leave the stack alone
                        r.status    = ST_BADCOUNT;
                        r.ref_count = page_refs[top];
                    end
                    else
                    begin
                        page_refs[top] = 8'd1;
                        free_depth--;
                        r.page_out   = top;
                        r.page_valid = 1'b1;
                        r.ref_count  = 8'd1;
                    end
                end
            end
            MODE_FREE:
            begin
                if (pg < first_cfg || pg >= lim)
                begin
                    r.status    = ST_RANGE;
                    r.ref_count = page_refs[pg];
                end
                else if (page_refs[pg] == 0)
                    r.status = ST_BADCOUNT;
                else
                begin
                    page_refs[pg]--;
                    r.ref_count = page_refs[pg];
                    if (page_refs[pg] == 0)
                    begin
                        push_free(pg);
                        r.page_released = 1'b1;
                    end
                end
            end
            default:
            begin
                // Add-reference checks only the upper bound
                if (pg >= lim)
                begin
                    r.status    = ST_RANGE;
                    r.ref_count = page_refs[pg];
                end
                else if (page_refs[pg] == 0)
                    r.status = ST_BADCOUNT;
                else if (page_refs[pg] == CNT_MAX)
                begin
                    r.status    = ST_OVERFLOW;
                    r.ref_count = CNT_MAX;
                end
                else
                begin
                    page_refs[pg]++;
                    r.ref_count = page_refs[pg];
                end
            end
        endcase
        r.stack_fill = 16'(free_depth);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed table rows
    // ------------------------------------------------------------------

    function automatic stim_row_t cfg_row(input logic [15:0] f, input logic [15:0] e);
        stim_row_t r;
        r.is_cfg    = 1'b1;
        r.first_val = f;
        r.end_val   = e;
        r.mode      = MODE_INIT;
        r.page      = '0;
        r.typed     = 1'b0;
        r.result    = '0;
        return r;
    endfunction

    function automatic stim_row_t req_row(input mode_t m, input logic [14:0] pg);
        stim_row_t r;
        r.is_cfg    = 1'b0;
        r.first_val = '0;
        r.end_val   = '0;
        r.mode      = m;
        r.page      = pg;
        r.typed     = 1'b0;
        r.result    = '0;
        return r;
    endfunction

    function automatic stim_row_t chk_row(input mode_t m, input logic [14:0] pg,
                                          input logic [14:0] po, input logic v,
                                          input status_t st, input logic rel,
                                          input logic [7:0] cnt, input logic [15:0] fp);
        stim_row_t r;
        r                      = req_row(m, pg);
        r.typed                = 1'b1;
        r.result.page_out      = po;
        r.result.page_valid    = v;
        r.result.status        = st;
        r.result.page_released = rel;
        r.result.ref_count     = cnt;
        r.result.stack_fill    = fp;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Present one request and hold it until accepted. Keep s_tvalid high on
    // return so a follow-up request in the same burst goes out back to back.
    task automatic issue_request(input mode_t m, input logic [14:0] pg,
                                 input bit typed, input alloc_result_t typed_res);
        alloc_result_t predicted;
        if (burst_left == 0)
        begin
            // Close the burst, idle for a while, then start a new one
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, pg};
        s_tuser  <= m;
        predicted = predict_frame_op(m, pg);
        pending_results.push_back(typed ? typed_res : predicted);
        requests_sent++;
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
    endtask

    // Drop the request stream and wait until every result is back
    task automatic wait_idle();
        s_tvalid   <= 1'b0;
        burst_left  = 0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Write both bounds back to back on the configuration channel
    task automatic write_bounds(input logic [15:0] first_val, input logic [15:0] end_val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_FIRST_PAGE;
        cfg_data  <= first_val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= CFG_END_PAGE;
        cfg_data  <= end_val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        first_cfg  = first_val[14:0];
        end_cfg    = end_val;
        @(posedge clk);
    endtask

    // Random page inside the managed range, or the first page if it is empty
    function automatic logic [14:0] page_in_range();
        int unsigned lim;
        lim = managed_end();
        if (lim <= first_cfg)
            return first_cfg[14:0];
        return 15'(first_cfg + $urandom_range(0, lim - first_cfg - 1));
    endfunction

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got_v);
        if (want != got_v)
        begin
            $error("%s: expected %0d, got %0d", name, want, got_v);
            mismatches++;
        end
    endfunction

    // Receiver stall pattern: switch between styles at random, with
    // always-ready stretches among them
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style <= $urandom_range(0, 3);
            stall_left  <= $urandom_range(16, 200);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_style)
            0:       m_tready <= 1'b1;
            1:       m_tready <= $urandom_range(0, 1);
            2:       m_tready <= (cycle_count % 4 == 0);
            default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Compare each accepted result with the oldest pending expectation
    always @(posedge clk)
    begin
        alloc_result_t want;
        alloc_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = alloc_result_t'(m_tdata);
            if (pending_results.size() == 0)
            begin
                $error("result with no request pending: %h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("page_out", want.page_out, got.page_out);
                check_field("page_valid", want.page_valid, got.page_valid);
                check_field("status", want.status, got.status);
                check_field("page_released", want.page_released, got.page_released);
                check_field("ref_count", want.ref_count, got.ref_count);
                check_field("stack_fill", want.stack_fill, got.stack_fill);
            end
        end
    end

    // Hard stop if the run hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin
        int unsigned   lim;
        int unsigned   n_ops;
        int unsigned   pick;
        int unsigned   phase;
        int unsigned   f;
        int unsigned   e;
        bit            hammer_done;
        logic [14:0]   pg;

        // Shadow state matches the block after reset
        foreach (page_refs[i])
            page_refs[i] = '0;
        foreach (free_list[i])
            free_list[i] = '0;
        free_depth    = 0;
        first_cfg     = 0;
        end_cfg       = 32768;
        mismatches    = 0;
        requests_sent = 0;
        cycle_count   = 0;
        burst_left    = 0;
        stall_left    = 0;
        stall_style   = 0;
        hammer_done   = 1'b0;

        // Straight after reset: everything empty and every count zero
        directed_rows.push_back(chk_row(MODE_ALLOC, 15'd0, 15'd0, 1'b0, ST_EMPTY,
                                        1'b0, 8'd0, 16'd0));
        directed_rows.push_back(chk_row(MODE_FREE, 15'h7FFF, 15'h7FFF, 1'b0, ST_BADCOUNT,
                                        1'b0, 8'd0, 16'd0));
        directed_rows.push_back(chk_row(MODE_ADDREF, 15'd0, 15'd0, 1'b0, ST_BADCOUNT,
                                        1'b0, 8'd0, 16'd0));
        // Single managed page at the very top of the page space
        directed_rows.push_back(cfg_row(16'd32767, 16'd32768));
        directed_rows.push_back(chk_row(MODE_INIT, 15'h2AAA, 15'h2AAA, 1'b0, ST_OK,
                                        1'b0, 8'd0, 16'd1));
        directed_rows.push_back(chk_row(MODE_ALLOC, 15'h1234, 15'h7FFF, 1'b1, ST_OK,
                                        1'b0, 8'd1, 16'd0));
        directed_rows.push_back(req_row(MODE_ADDREF, 15'h7FFF));
        // Free below first page, add-reference below first page (no lower bound)
        directed_rows.push_back(chk_row(MODE_FREE, 15'd0, 15'd0, 1'b0, ST_RANGE,
                                        1'b0, 8'd0, 16'd0));
        directed_rows.push_back(chk_row(MODE_ADDREF, 15'd0, 15'd0, 1'b0, ST_BADCOUNT,
                                        1'b0, 8'd0, 16'd0));
        directed_rows.push_back(chk_row(MODE_ALLOC, 15'h7FFF, 15'h7FFF, 1'b0, ST_EMPTY,
                                        1'b0, 8'd0, 16'd0));
        // Drop both references; the second one releases the page
        directed_rows.push_back(req_row(MODE_FREE, 15'h7FFF));
        directed_rows.push_back(chk_row(MODE_FREE, 15'h7FFF, 15'h7FFF, 1'b0, ST_OK,
                                        1'b1, 8'd0, 16'd1));
        directed_rows.push_back(chk_row(MODE_FREE, 15'h7FFF, 15'h7FFF, 1'b0, ST_BADCOUNT,
                                        1'b0, 8'd0, 16'd1));
        // Smallest range: page 0 only
        directed_rows.push_back(cfg_row(16'd0, 16'd1));
        directed_rows.push_back(chk_row(MODE_ADDREF, 15'h7FFF, 15'h7FFF, 1'b0, ST_RANGE,
                                        1'b0, 8'd0, 16'd1));
        directed_rows.push_back(chk_row(MODE_INIT, 15'd0, 15'd0, 1'b0, ST_OK,
                                        1'b0, 8'd0, 16'd1));
        directed_rows.push_back(chk_row(MODE_ALLOC, 15'd0, 15'd0, 1'b1, ST_OK,
                                        1'b0, 8'd1, 16'd0));
        directed_rows.push_back(req_row(MODE_ADDREF, 15'd0));
        // Empty range: first page above the end
        directed_rows.push_back(cfg_row(16'd5, 16'd3));
        directed_rows.push_back(chk_row(MODE_INIT, 15'd0, 15'd0, 1'b0, ST_OK,
                                        1'b0, 8'd0, 16'd0));
        directed_rows.push_back(req_row(MODE_FREE, 15'd0));
        directed_rows.push_back(chk_row(MODE_ADDREF, 15'd4, 15'd4, 1'b0, ST_RANGE,
                                        1'b0, 8'd0, 16'd0));
        directed_rows.push_back(req_row(MODE_ADDREF, 15'd2));
        // Whole page space on the stack once
        directed_rows.push_back(cfg_row(16'd0, 16'd32768));
        directed_rows.push_back(chk_row(MODE_INIT, 15'h7FFF, 15'h7FFF, 1'b0, ST_OK,
                                        1'b0, 8'd0, 16'd32768));
        directed_rows.push_back(chk_row(MODE_ALLOC, 15'd0, 15'h7FFF, 1'b1, ST_OK,
                                        1'b0, 8'd1, 16'd32767));
        directed_rows.push_back(req_row(MODE_ALLOC, 15'h5555));
        directed_rows.push_back(req_row(MODE_FREE, 15'h7FFF));

        // Hold reset, then release it on a clock edge
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                write_bounds(directed_rows[i].first_val, directed_rows[i].end_val);
            else
                issue_request(directed_rows[i].mode, directed_rows[i].page,
                              directed_rows[i].typed, directed_rows[i].result);
        end

        // Random phases: new bounds, usually an init, then mostly well-formed
        // allocate / add-reference / free traffic inside the range with some noise
        phase = 0;
        while (requests_sent < directed_rows.size() + RANDOM_ITEMS)
        begin
            phase++;
            if (phase == 3 && !hammer_done)
            begin
                // Drive one page's count up to the ceiling and past it
                f = $urandom_range(0, 32766);
                write_bounds(16'(f), 16'(f + 1));
                issue_request(MODE_INIT, 15'($urandom), 1'b0, '0);
                issue_request(MODE_ALLOC, 15'($urandom), 1'b0, '0);
                repeat (256)
                    issue_request(MODE_ADDREF, f[14:0], 1'b0, '0);
                repeat (3)
                    issue_request(MODE_FREE, f[14:0], 1'b0, '0);
                hammer_done = 1'b1;
                continue;
            end

            if ($urandom_range(0, 7) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        f = 0;
                        e = $urandom_range(1, 24);
                    end
                    1:
                    begin
                        f = 32767 - $urandom_range(0, 24);
                        e = 32768;
                    end
                    2:
                    begin
                        f = $urandom_range(100, 32767);
                        e = $urandom_range(1, f);
                    end
                    default:
                    begin
                        f = 32767;
                        e = 32768;
                    end
                endcase
            end
            else
            begin
                f = $urandom_range(0, 32767);
                e = f + $urandom_range(0, 40);
                if (e > 32768)
                    e = 32768;
            end
            write_bounds(16'(f), 16'(e));
            // Skip the init now and then so stale pages and counts carry over
            if ($urandom_range(0, 4) != 0)
                issue_request(MODE_INIT, 15'($urandom), 1'b0, '0);

            n_ops = $urandom_range(20, 60);
            repeat (n_ops)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    issue_request(MODE_ALLOC, 15'($urandom), 1'b0, '0);
                else if (pick < 65)
                    issue_request(MODE_FREE, page_in_range(), 1'b0, '0);
                else if (pick < 85)
                    issue_request(MODE_ADDREF, page_in_range(), 1'b0, '0);
                else if (pick < 93)
                    issue_request(mode_t'($urandom_range(0, 3)), 15'($urandom), 1'b0, '0);
                else
                begin
                    // Just outside either bound
                    lim = managed_end();
                    pg  = $urandom_range(0, 1) ? 15'(first_cfg - 1) : 15'(lim);
                    issue_request($urandom_range(0, 1) ? MODE_FREE : MODE_ADDREF, pg,
                                  1'b0, '0);
                end
            end
        end

        // Drain: everything back, then a quiet spell of DRAIN_CYCLES for stray results
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
